// File: hw/rtl/hsvh_pkg.sv
package hsvh_pkg;

  localparam int unsigned CountWidth = 25;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam int unsigned FracWidth = 17;

  localparam logic [2:0] RegBoxXStart = 3'd0;
  localparam logic [2:0] RegBoxYStart = 3'd1;
  localparam logic [2:0] RegBoxXEnd = 3'd2;
  localparam logic [2:0] RegBoxYEnd = 3'd3;
  localparam logic [2:0] RegValueMin = 3'd4;
  localparam logic [2:0] RegSatMin = 3'd5;

  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    logic        start;
    logic [24:0] dividend;
    logic [24:0] divisor;
  } div_req_t;

endpackage

// File: hw/rtl/hsvh_ram.sv
module hsvh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/hsvh_divider.sv
module hsvh_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  hsvh_pkg::div_req_t           req,
  output logic                         done,
  output logic [hsvh_pkg::FracWidth-1:0] quotient
);
  import hsvh_pkg::*;

  // Restoring division of count*65536 by total, one quotient bit per cycle.
  localparam int unsigned Steps = 41;

  logic [5:0]  step;
  logic        active;
  logic [40:0] dividend;
  logic [25:0] rem;
  logic [24:0] divisor;
  logic [40:0] quo;
  logic [25:0] trial;
  logic [26:0] diff;

  assign trial = {rem[24:0], dividend[40]};
  assign diff = {1'b0, trial} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        step <= '0;
      end else if (active) begin
        step <= step + 6'd1;
        if (step == 6'(Steps - 1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= {req.dividend, 16'd0};
      divisor <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (active) begin
      dividend <= {dividend[39:0], 1'b0};
      if (!diff[26]) begin
        rem <= diff[25:0];
        quo <= {quo[39:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[39:0], 1'b0};
      end
    end
  end

  assign quotient = quo[FracWidth-1:0];

endmodule

// File: hw/rtl/hsvh_classify.sv
module hsvh_classify #(
  parameter int unsigned HUE_BINS = 8,
  parameter int unsigned SAT_BINS = 2,
  parameter int unsigned VAL_BINS = 2,
  parameter int unsigned BinWidth = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          value_min,
  input  logic [7:0]          sat_min,
  output logic                done,
  output logic                keep,
  output logic [BinWidth-1:0] bin
);
  import hsvh_pkg::*;

  // Hue bin found by a sequential search: hb is the count of k in 1..HUE_BINS-1
  // with num*HUE_BINS >= k*6d, one comparison per cycle.
  logic [7:0]  mx, mn, d;
  logic [11:0] num;
  logic [3:0]  hb;
  logic [4:0]  k;
  logic        busy;
  logic        sb;
  logic        vb;
  logic [16:0] lhs, rhs;

  logic [7:0]  c_mx, c_mn, c_d;
  logic [11:0] c_num;
  logic        c_keep;

  always_comb begin
    c_mx = red;
    if (green > c_mx) c_mx = green;
    if (blue > c_mx) c_mx = blue;
    c_mn = red;
    if (green < c_mn) c_mn = green;
    if (blue < c_mn) c_mn = blue;
    c_d = c_mx - c_mn;
    c_keep = (c_mx >= value_min) && ({c_d, 8'd0} >= 16'(sat_min) * 16'(c_mx));
    if (red >= green && red >= blue) begin
      c_num = (green >= blue) ? 12'(green - blue)
                              : 12'(12'd6 * 12'(c_d) - 12'(blue - green));
    end else if (green >= blue) begin
      c_num = 12'(12'd2 * 12'(c_d) + 12'(blue) - 12'(red));
    end else begin
      c_num = 12'(12'd4 * 12'(c_d) + 12'(red) - 12'(green));
    end
  end

  assign lhs = 17'(num) * 17'(HUE_BINS);
  assign rhs = 17'(k) * 17'(6) * 17'(d);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (k >= 5'(HUE_BINS) || d == 8'd0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx <= c_mx;
      mn <= c_mn;
      d <= c_d;
      num <= c_num;
      keep <= c_keep;
      hb <= '0;
      k <= 5'd1;
    end else if (busy && k < 5'(HUE_BINS) && d != 8'd0) begin
      if (lhs >= rhs) hb <= 4'(k);
      k <= k + 5'd1;
    end
  end

  always_comb begin
    if (SAT_BINS > 1) sb = (mx != 8'd0) && ({1'b0, d, 1'b0} >= {2'b0, mx});
    else sb = 1'b0;
    if (VAL_BINS > 1) vb = ({mx, 1'b0} >= 9'd255);
    else vb = 1'b0;
    bin = BinWidth'((32'(hb) * SAT_BINS + 32'(sb)) * VAL_BINS + 32'(vb));
  end

  logic unused;
  assign unused = ^mn;

endmodule

// File: hw/rtl/hsv_region_histogram.sv
// HSV colour histogram of a box in a pixel stream.
// Raise start with a pixel while busy is low; the pixel is taken on that edge
// and its fields may change afterwards.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// one beat per register; cfg_ready is high only while the block is idle and
// start is low.
// A pixel outside the box is consumed in its accept cycle. A pixel inside the
// box holds busy while the hue bin is found by one comparison per cycle (a
// grey pixel skips the search), and a counted pixel then passes through a read
// state and a write state to increment and write back its bin count.
// A pixel with frame_end set is handled first, then every bin is emitted in
// order, each as count*65536/total from the 41-step bit-serial divider; each
// bin is cleared in the RAM as it is read.
// Results appear on bin_index/bin_fraction/last_bin for one cycle with
// result_valid; the receiver cannot stall them.
// Reset sets the registers to their defaults and then sweeps every RAM
// address to zero, during which busy stays high.
module hsv_region_histogram #(
  parameter int unsigned HUE_BINS = 8,
  parameter int unsigned SAT_BINS = 2,
  parameter int unsigned VAL_BINS = 2,
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        result_valid,
  output logic [5:0]  bin_index,
  output logic [16:0] bin_fraction,
  output logic        last_bin
);
  import hsvh_pkg::*;

  localparam int unsigned NumBins = HUE_BINS * SAT_BINS * VAL_BINS;
  localparam int unsigned BinWidth = (NumBins > 1) ? $clog2(NumBins) : 1;

  typedef enum logic [7:0] {
    StClear  = 8'b00000001,
    StIdle   = 8'b00000010,
    StClass  = 8'b00000100,
    StRead   = 8'b00001000,
    StWrite  = 8'b00010000,
    StEmitRd = 8'b00100000,
    StDiv    = 8'b01000000,
    StOut    = 8'b10000000
  } state_t;

  state_t state, state_next;

  logic [11:0] box_x_start, box_y_start;
  logic [12:0] box_x_end, box_y_end;
  logic [7:0]  value_min, sat_min;
  count_t      total;
  logic        fe;
  logic        do_count;
  logic        in_box;
  logic [BinWidth-1:0] addr;
  logic [BinWidth-1:0] cls_bin;
  logic        cls_done, cls_keep;
  logic        ram_we;
  logic [BinWidth-1:0] ram_waddr, ram_raddr;
  count_t      ram_wdata, ram_rdata;
  div_req_t    div_req;
  logic        div_done;
  logic [16:0] div_q;
  logic        box_narrow;

  assign cfg_ready = (state == StIdle) && !start;
  assign busy = (state != StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_start <= '0;
      box_y_start <= '0;
      box_x_end <= 13'(MAX_DIM);
      box_y_end <= 13'(MAX_DIM);
      value_min <= 8'd31;
      sat_min <= 8'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegBoxXStart: box_x_start <= cfg_data[11:0];
        RegBoxYStart: box_y_start <= cfg_data[11:0];
        RegBoxXEnd: box_x_end <= cfg_data;
        RegBoxYEnd: box_y_end <= cfg_data;
        RegValueMin: value_min <= cfg_data[7:0];
        RegSatMin: sat_min <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_box = ({1'b0, pixel_x} >= {1'b0, box_x_start}) && ({1'b0, pixel_x} < box_x_end)
               && ({1'b0, pixel_y} >= {1'b0, box_y_start}) && ({1'b0, pixel_y} < box_y_end);
  assign box_narrow = (box_x_end < 13'(box_x_start) + 13'd4)
                   || (box_y_end < 13'(box_y_start) + 13'd4);

  hsvh_classify #(
    .HUE_BINS(HUE_BINS), .SAT_BINS(SAT_BINS), .VAL_BINS(VAL_BINS), .BinWidth(BinWidth)
  ) u_classify (
    .clk, .rst,
    .start(state == StIdle && start && in_box),
    .red, .green, .blue, .value_min, .sat_min,
    .done(cls_done), .keep(cls_keep), .bin(cls_bin)
  );

  hsvh_ram #(.Width(CountWidth), .Depth(2 ** BinWidth)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  hsvh_divider u_div (.clk, .rst, .req(div_req), .done(div_done), .quotient(div_q));

  assign ram_raddr = (state == StClass) ? cls_bin : addr;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    if (state == StClear) ram_we = 1'b1;
    if (state == StWrite) begin
      ram_we = (ram_rdata != CountMax);
      ram_wdata = ram_rdata + 25'd1;
    end
    if (state == StEmitRd) ram_we = 1'b1;
  end

  always_comb begin
    div_req.start = (state == StEmitRd);
    div_req.dividend = ram_rdata;
    div_req.divisor = total;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      StClear: if (addr == BinWidth'(2 ** BinWidth - 1)) state_next = StIdle;
      StIdle: if (start) begin
        if (in_box) state_next = StClass;
        else if (frame_end) state_next = StRead;
      end
      StClass: if (cls_done) begin
        if ((cls_keep && total != CountMax) || fe) state_next = StRead;
        else state_next = StIdle;
      end
      StRead: state_next = do_count ? StWrite : StEmitRd;
      StWrite: state_next = fe ? StRead : StIdle;
      StEmitRd: state_next = StDiv;
      StDiv: if (div_done) state_next = StOut;
      StOut: state_next = (addr == BinWidth'(NumBins - 1)) ? StIdle : StRead;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      addr <= '0;
      total <= '0;
      fe <= 1'b0;
      do_count <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      unique case (state)
        StClear: addr <= addr + BinWidth'(1);
        StIdle: begin
          fe <= frame_end;
          do_count <= 1'b0;
          if (start && !in_box && frame_end) addr <= '0;
        end
        StClass: if (cls_done) begin
          if (cls_keep && total != CountMax) begin
            addr <= cls_bin;
            do_count <= 1'b1;
          end else if (fe) begin
            addr <= '0;
          end
        end
        StWrite: begin
          total <= total + 25'd1;
          do_count <= 1'b0;
          if (fe) addr <= '0;
        end
        StDiv: if (div_done) result_valid <= 1'b1;
        StOut: begin
          if (addr == BinWidth'(NumBins - 1)) total <= '0;
          else addr <= addr + BinWidth'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == StDiv && div_done) begin
      bin_index <= 6'(addr);
      bin_fraction <= (box_narrow || total == '0) ? 17'd0 : div_q;
      last_bin <= (addr == BinWidth'(NumBins - 1));
    end
  end

endmodule

// File: dv/hsv_region_histogram_checker.sv
module hsv_region_histogram_checker
  import hsvh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        result_valid,
  input  logic [5:0]  bin_index,
  input  logic [16:0] bin_fraction,
  input  logic        last_bin,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int unsigned HueBins = 8;
  localparam int unsigned SatBins = 2;
  localparam int unsigned ValBins = 2;
  localparam int unsigned NumBins = HueBins * SatBins * ValBins;

  typedef struct {
    logic [5:0]  index;
    logic [16:0] fraction;
    logic        last;
  } bin_beat_t;

  bin_beat_t   bins_due[$];
  count_t      tally[NumBins];
  count_t      tally_total;
  logic [11:0] x_lo, y_lo;
  logic [12:0] x_hi, y_hi;
  logic [7:0]  dark_limit, grey_limit;

  // Returns the bin a pixel falls into, or -1 when it is too dark or too grey.
  function automatic int colour_bin(int unsigned r, int unsigned g, int unsigned b);
    int unsigned mx, mn, d, num, hb, sb, vb;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (mx < dark_limit) return -1;
    if (256 * d < grey_limit * mx) return -1;
    if (d == 0) begin
      hb = 0;
    end else begin
      if (r >= g && r >= b) num = (g >= b) ? g - b : 6 * d - (b - g);
      else if (g >= b) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      hb = (num * HueBins) / (6 * d);
      if (hb >= HueBins) hb = HueBins - 1;
    end
    sb = (mx == 0) ? 0 : (SatBins * d) / mx;
    if (sb >= SatBins) sb = SatBins - 1;
    vb = (ValBins * mx) / 255;
    if (vb >= ValBins) vb = ValBins - 1;
    return int'((hb * SatBins + sb) * ValBins + vb);
  endfunction

  task automatic count_and_emit();
    int         slot;
    bit         narrow;
    bin_beat_t  beat;
    logic [63:0] q;
    if (pixel_x >= x_lo && pixel_x < x_hi && pixel_y >= y_lo && pixel_y < y_hi &&
        tally_total != CountMax) begin
      slot = colour_bin(red, green, blue);
      if (slot >= 0) begin
        if (tally[slot] != CountMax) tally[slot]++;
        tally_total++;
      end
    end
    if (frame_end) begin
      narrow = (int'(x_hi) < int'(x_lo) + 4) || (int'(y_hi) < int'(y_lo) + 4);
      for (int i = 0; i < NumBins; i++) begin
        q = 0;
        if (!narrow && tally_total != 0) q = {tally[i], 16'd0} / tally_total;
        beat.index = i[5:0];
        beat.fraction = q[16:0];
        beat.last = (i == NumBins - 1);
        bins_due.push_back(beat);
        tally[i] = '0;
      end
      tally_total = '0;
    end
  endtask

  always @(posedge clk) begin
    bin_beat_t want;
    if (rst) begin
      x_lo = '0;
      y_lo = '0;
      x_hi = 13'd4096;
      y_hi = 13'd4096;
      dark_limit = 8'd31;
      grey_limit = 8'd15;
      foreach (tally[i]) tally[i] = '0;
      tally_total = '0;
      bins_due.delete();
    end else begin
      if (result_valid) begin
        checked++;
        if (bins_due.size() == 0) begin
          $error("unexpected result beat, bin_index %0d", bin_index);
          fail_count++;
        end else begin
          want = bins_due.pop_front();
          if (bin_index !== want.index) begin
            $error("bin_index: expected %0d, got %0d", want.index, bin_index);
            fail_count++;
          end
          if (bin_fraction !== want.fraction) begin
            $error("bin_fraction: expected %0d, got %0d (bin %0d)",
                   want.fraction, bin_fraction, want.index);
            fail_count++;
          end
          if (last_bin !== want.last) begin
            $error("last_bin: expected %0d, got %0d", want.last, last_bin);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegBoxXStart: x_lo = cfg_data[11:0];
          RegBoxYStart: y_lo = cfg_data[11:0];
          RegBoxXEnd:   x_hi = cfg_data;
          RegBoxYEnd:   y_hi = cfg_data;
          RegValueMin:  dark_limit = cfg_data[7:0];
          RegSatMin:    grey_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy) count_and_emit();
    end
    pending = bins_due.size();
  end

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
  end

endmodule

// File: dv/tb_hsv_region_histogram.sv
module tb_hsv_region_histogram;
  import hsvh_pkg::*;

  localparam int IdleLimit = 3000;
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] pixel_x = '0, pixel_y = '0;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic        frame_end = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        result_valid;
  logic [5:0]  bin_index;
  logic [16:0] bin_fraction;
  logic        last_bin;
  int          fail_count, pending, checked;
  int          pixels_sent = 0, frames_sent = 0, idle_cycles = 0;
  bit          steady = 1'b0;

  hsv_region_histogram dut (.*);
  hsv_region_histogram_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic maybe_pause();
    while (!steady && $urandom_range(99) < 9) begin
      start = 1'b0;
      cfg_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_pixel(int x, int y, int r, int g, int b, bit fe);
    maybe_pause();
    pixel_x = 12'(x);
    pixel_y = 12'(y);
    red = 8'(r);
    green = 8'(g);
    blue = 8'(b);
    frame_end = fe;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
    if (fe) frames_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    start = 1'b0;
    maybe_pause();
    cfg_index = idx;
    cfg_data = 13'(value);
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_box(int xs, int ys, int xe, int ye);
    write_reg(RegBoxXStart, xs);
    write_reg(RegBoxYStart, ys);
    write_reg(RegBoxXEnd, xe);
    write_reg(RegBoxYEnd, ye);
  endtask

  int xs, ys, xe, ye, span_x, span_y, n, x, y, r, g, b, phase;

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Default registers: colour corners, ties, hue wrap, grey and dark pixels.
    send_pixel(0, 0, 255, 0, 0, 0);
    send_pixel(4095, 4095, 0, 255, 0, 0);
    send_pixel(10, 20, 0, 0, 255, 0);
    send_pixel(11, 21, 200, 200, 10, 0);
    send_pixel(12, 22, 40, 90, 90, 0);
    send_pixel(13, 23, 255, 0, 1, 0);
    send_pixel(14, 24, 128, 128, 128, 0);
    send_pixel(15, 25, 255, 255, 255, 0);
    send_pixel(16, 26, 30, 0, 0, 0);
    send_pixel(17, 27, 200, 190, 180, 1);
    drain();

    write_reg(RegValueMin, 0);
    write_reg(RegSatMin, 0);
    set_box(0, 0, 4096, 4096);
    send_pixel(1, 1, 0, 0, 0, 0);
    send_pixel(2, 2, 77, 77, 77, 0);
    send_pixel(3, 3, 255, 255, 0, 1);
    send_pixel(3, 3, 9, 9, 9, 1);
    drain();

    set_box(100, 200, 103, 300);
    send_pixel(101, 250, 255, 0, 0, 0);
    send_pixel(102, 250, 0, 200, 50, 1);
    set_box(500, 500, 400, 400);
    send_pixel(450, 450, 0, 200, 50, 1);
    drain();

    write_reg(RegValueMin, 255);
    write_reg(RegSatMin, 255);
    set_box(4092, 4092, 4096, 4096);
    send_pixel(4093, 4095, 255, 0, 0, 0);
    send_pixel(4095, 4092, 255, 1, 0, 0);
    send_pixel(4091, 4093, 255, 0, 0, 1);
    drain();

    write_reg(RegSpareLo, 13'h1fff);
    write_reg(RegSpareHi, 13'h0aaa);
    send_pixel(4095, 4095, 255, 0, 0, 1);
    drain();

    phase = 0;
    while (pixels_sent < 300) begin
      steady = (phase >= 3 && phase < 6);
      case ($urandom_range(3))
        0: begin xs = 0; ys = 0; xe = 4096; ye = 4096; end
        1: begin
          xs = $urandom_range(4095);
          ys = $urandom_range(4095);
          xe = xs + $urandom_range(300);
          ye = ys + $urandom_range(300);
          if (xe > 4096) xe = 4096;
          if (ye > 4096) ye = 4096;
        end
        2: begin
          xs = $urandom_range(4095);
          ys = $urandom_range(4095);
          xe = $urandom_range(4096);
          ye = $urandom_range(4096);
        end
        default: begin
          xs = $urandom_range(200);
          ys = $urandom_range(200);
          xe = xs + $urandom_range(6, 40);
          ye = ys + $urandom_range(6, 40);
        end
      endcase
      set_box(xs, ys, xe, ye);
      case ($urandom_range(3))
        0: write_reg(RegValueMin, 0);
        1: write_reg(RegValueMin, 255);
        default: write_reg(RegValueMin, $urandom_range(80));
      endcase
      case ($urandom_range(3))
        0: write_reg(RegSatMin, 0);
        1: write_reg(RegSatMin, 255);
        default: write_reg(RegSatMin, $urandom_range(60));
      endcase
      span_x = (xe > xs) ? xe - xs : 1;
      span_y = (ye > ys) ? ye - ys : 1;
      n = $urandom_range(12, 36);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 85) begin
          x = xs + $urandom_range(span_x - 1);
          y = ys + $urandom_range(span_y - 1);
          if (x > 4095) x = 4095;
          if (y > 4095) y = 4095;
        end else begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
        end
        r = $urandom_range(255);
        g = $urandom_range(255);
        b = $urandom_range(255);
        case ($urandom_range(7))
          0: begin g = r; b = r; end
          1: g = r;
          2: b = g;
          default: ;
        endcase
        send_pixel(x, y, r, g, b, (i == n - 1) || ($urandom_range(14) == 0));
      end
      drain();
      phase++;
    end
    steady = 1'b0;

    $display("Sent %0d pixels in %0d frames and checked %0d histogram bins,", pixels_sent,
             frames_sent, checked);
    $display("across default, extreme, narrow, inverted and random box settings.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
